@@ src/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the stack pointer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int unsigned AddrBits   = 11;
  localparam int unsigned StackDepth = 2 ** AddrBits;
  localparam int unsigned PtrExtW    = 16;
  localparam int unsigned FieldPtrW  = 11;
  localparam int unsigned RetAddrW   = 22;
  localparam int unsigned CfgDataW   = 11;

  localparam bit SmallSpace = (StackDepth <= 256);

  localparam logic [1:0]           CfgPcBytesRst  = 2'd2;
  localparam logic                 CfgInitTopRst  = 1'b1;
  localparam logic [CfgDataW-1:0]  CfgTopAddrRst  = 11'd1119;
  localparam logic [AddrBits-1:0]  PtrRst         = AddrBits'(CfgTopAddrRst);

  typedef enum logic [3:0] {
    ActPush      = 4'd0,
    ActPop       = 4'd1,
    ActPushAddr  = 4'd2,
    ActPopAddr   = 4'd3,
    ActWriteLow  = 4'd4,
    ActWriteHigh = 4'd5,
    ActReadLow   = 4'd6,
    ActReadHigh  = 4'd7,
    ActReinit    = 4'd8
  } ssp_action_e;

  typedef enum logic [1:0] {
    CfgPcBytes    = 2'd0,
    CfgInitAtTop  = 2'd1,
    CfgTopAddress = 2'd2
  } ssp_cfg_e;

  typedef struct packed {
    logic [3:0]          action;
    logic [7:0]          data_byte;
    logic [RetAddrW-1:0] return_address;
  } ssp_in_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic [RetAddrW-1:0]  popped_address;
    logic [FieldPtrW-1:0] pointer_now;
    logic [FieldPtrW-1:0] lowest_pointer;
    logic                 missing_high_flag;
  } ssp_out_t;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [AddrBits-1:0] addr;
    logic [7:0]          wdata;
  } ssp_mem_req_t;

endpackage

`default_nettype wire

@@ src/sram_stack_pointer_unit.sv @@
// ----------------------------------------------------------------------------
// sram_stack_pointer_unit
// Stack pointer unit with a private byte-wide stack RAM.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i | request in
//  out     | out_valid_o, out_stall_i, out_data_o | result out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
//  Push and pop make one RAM access each; the pointer byte actions, reinit
//  and unused codes make none; push or pop of an address makes one access
//  per byte on the single RAM port, two or three bytes as set by CfgPcBytes.
//  After reset the RAM is cleared, one entry per cycle, all 2**AddrBits
//  entries (2048) with in_stall_o high. Config writes are taken at any time.
//  A new request is accepted while the previous result waits in the output
//  register; a stalled output holds the sequencer at its last cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sram_stack_pointer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ssp_pkg::ssp_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ssp_pkg::ssp_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [ssp_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                         clr_q, clr_d;
  logic [ssp_pkg::AddrBits-1:0] clr_cnt_q, clr_cnt_d;
  logic                         seq_idle, start;
  logic                         res_valid, res_free;
  ssp_pkg::ssp_out_t            res;
  ssp_pkg::ssp_mem_req_t        seq_req, mem_req;
  logic [7:0]                   mem_rdata;

  // clearing pass
  assign clr_cnt_d = clr_cnt_q + 1'b1;
  assign clr_d     = clr_q && (clr_cnt_q != '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign in_stall_o  = clr_q || !seq_idle;
  assign start       = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign mem_req = clr_q ? ssp_pkg::ssp_mem_req_t'{en: 1'b1, we: 1'b1, addr: clr_cnt_q,
                                                   wdata: 8'h00}
                         : seq_req;

  ssp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start),
    .in_data_i   (in_data_i),
    .idle_o      (seq_idle),
    .mem_req_o   (seq_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_free_i  (res_free),
    .res_o       (res)
  );

  ssp_ram #(
    .Width (8),
    .Depth (ssp_pkg::StackDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  ssp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/ssp_ram.sv @@
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/ssp_seq.sv @@
// ----------------------------------------------------------------------------
// ssp_seq
// Request sequencer: pointer, low-water mark, config registers and
// byte-by-byte stack memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [ssp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                  start_i,
  input  ssp_pkg::ssp_in_t      in_data_i,
  output logic                  idle_o,
  output ssp_pkg::ssp_mem_req_t mem_req_o,
  input  logic [7:0]            mem_rdata_i,
  output logic                  res_valid_o,
  input  logic                  res_free_i,
  output ssp_pkg::ssp_out_t     res_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } ssp_state_e;

  ssp_state_e state_q, state_d;

  logic [1:0]                   cfg_pc_q;
  logic                         cfg_init_q;
  logic [ssp_pkg::CfgDataW-1:0] cfg_top_q;

  logic [ssp_pkg::AddrBits-1:0] ptr_q, ptr_d, low_q, low_d;
  logic [ssp_pkg::AddrBits-1:0] ptr_inc, ptr_dec, ptr_init;
  logic [ssp_pkg::PtrExtW-1:0]  ptr_ext, low_ext;
  logic [1:0]                   rem_q, rem_d, n_addr;
  logic                         push_q, push_d;
  logic                         pend_q, pend_d;
  logic [23:0]                  sh_q, sh_d, acc_next;
  logic [3:0]                   act_q, act_d;
  logic [7:0]                   rd_q, rd_d;
  logic                         flag_q, flag_d;
  logic                         fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pc_q   <= ssp_pkg::CfgPcBytesRst;
      cfg_init_q <= ssp_pkg::CfgInitTopRst;
      cfg_top_q  <= ssp_pkg::CfgTopAddrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssp_pkg::CfgPcBytes:    cfg_pc_q   <= cfg_data_i[1:0];
        ssp_pkg::CfgInitAtTop:  cfg_init_q <= cfg_data_i[0];
        ssp_pkg::CfgTopAddress: cfg_top_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ptr_inc  = ptr_q + 1'b1;
  assign ptr_dec  = ptr_q - 1'b1;
  assign ptr_ext  = ssp_pkg::PtrExtW'(ptr_q);
  assign low_ext  = ssp_pkg::PtrExtW'(low_q);
  assign ptr_init = cfg_init_q ? ssp_pkg::AddrBits'(cfg_top_q) : '0;
  assign n_addr   = (cfg_pc_q == 2'd3) ? 2'd3 : 2'd2;
  assign acc_next = pend_q ? {sh_q[15:0], mem_rdata_i} : sh_q;
  assign fin      = (state_q == StRun) && (rem_q == 2'd0);
  assign idle_o   = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    low_d     = low_q;
    rem_d     = rem_q;
    push_d    = push_q;
    pend_d    = 1'b0;
    sh_d      = push_q ? sh_q : acc_next;
    act_d     = act_q;
    rd_d      = rd_q;
    flag_d    = flag_q;
    mem_req_o = '0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StRun;
          act_d   = in_data_i.action;
          rd_d    = '0;
          flag_d  = 1'b0;
          rem_d   = 2'd0;
          push_d  = 1'b0;
          sh_d    = '0;
          case (in_data_i.action)
            ssp_pkg::ActPush: begin
              push_d = 1'b1;
              rem_d  = 2'd1;
              sh_d   = 24'(in_data_i.data_byte);
            end
            ssp_pkg::ActPop: begin
              rem_d = 2'd1;
            end
            ssp_pkg::ActPushAddr: begin
              push_d = 1'b1;
              rem_d  = n_addr;
              sh_d   = 24'(in_data_i.return_address);
            end
            ssp_pkg::ActPopAddr: begin
              rem_d = n_addr;
            end
            ssp_pkg::ActWriteLow: begin
              ptr_d = ssp_pkg::AddrBits'({ptr_ext[15:8], in_data_i.data_byte});
            end
            ssp_pkg::ActWriteHigh: begin
              ptr_d  = ssp_pkg::AddrBits'({in_data_i.data_byte, ptr_ext[7:0]});
              flag_d = ssp_pkg::SmallSpace;
            end
            ssp_pkg::ActReadLow: begin
              rd_d = ptr_ext[7:0];
            end
            ssp_pkg::ActReadHigh: begin
              rd_d = ptr_ext[15:8];
            end
            ssp_pkg::ActReinit: begin
              ptr_d = ptr_init;
              low_d = ptr_init;
            end
            default: ;
          endcase
        end
      end
      StRun: begin
        if (rem_q != 2'd0) begin
          rem_d = rem_q - 2'd1;
          if (push_q) begin
            mem_req_o = '{en: 1'b1, we: 1'b1, addr: ptr_q, wdata: sh_q[7:0]};
            sh_d      = {8'h00, sh_q[23:8]};
            ptr_d     = ptr_dec;
            if (low_q > ptr_dec) begin
              low_d = ptr_dec;
            end
          end else begin
            mem_req_o = '{en: 1'b1, we: 1'b0, addr: ptr_inc, wdata: 8'h00};
            ptr_d     = ptr_inc;
            pend_d    = 1'b1;
          end
        end else if (res_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ptr_q   <= ssp_pkg::PtrRst;
      low_q   <= ssp_pkg::PtrRst;
      rem_q   <= 2'd0;
      push_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      low_q   <= low_d;
      rem_q   <= rem_d;
      push_q  <= push_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    act_q  <= act_d;
    rd_q   <= rd_d;
    flag_q <= flag_d;
  end

  assign res_valid_o = fin;

  always_comb begin
    res_o.read_data         = (act_q == ssp_pkg::ActPop) ? acc_next[7:0] : rd_q;
    res_o.popped_address    = (act_q == ssp_pkg::ActPopAddr) ?
                              acc_next[ssp_pkg::RetAddrW-1:0] : '0;
    res_o.pointer_now       = ptr_ext[ssp_pkg::FieldPtrW-1:0];
    res_o.lowest_pointer    = low_ext[ssp_pkg::FieldPtrW-1:0];
    res_o.missing_high_flag = flag_q;
  end

endmodule

`default_nettype wire

@@ src/ssp_outbuf.sv @@
// ----------------------------------------------------------------------------
// ssp_outbuf
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ssp_pkg::ssp_out_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssp_pkg::ssp_out_t out_data_o
);

  logic              valid_q, valid_d;
  ssp_pkg::ssp_out_t data_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = (load_i && free_o) || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ src/ssp_checker.sv @@
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks of the stack pointer unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ssp_pkg::ssp_out_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  // one request in flight: accept closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a result carries either a popped byte or a popped address, never both
  a_rd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.read_data == 8'h00 || out_data_o.popped_address == '0)
    else $error("read_data and popped_address both set");

  a_flag_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.missing_high_flag |-> ssp_pkg::SmallSpace)
    else $error("missing high flag with large stack space");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind sram_stack_pointer_unit ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
